FILE: hdl/mbe_pkg.sv
// shared constants, command and status types for the mandelbrot escape test
`timescale 1ns / 1ps
`default_nettype none

package mbe_pkg;

  // fixed-point format of the point and of z
  localparam int FRAC_BITS  = 28;
  // fraction bits used by the cardioid and bulb tests
  localparam int GUARD_BITS = (FRAC_BITS > 28) ? 28 : FRAC_BITS;
  localparam int DISC_SHIFT = FRAC_BITS - GUARD_BITS;

  // hard cap on the number of iteration steps
  localparam int ITER_LIMIT = 16384;

  // iteration counter and register width
  localparam int CNT_W = 14;
  localparam logic [CNT_W-1:0] MAX_ITER_RESET = CNT_W'(1000);
  localparam logic [CNT_W-1:0] DIV5_RESET     = CNT_W'(200);

  // floor(m / 5) as (m * 52429) >> 18, exact for all 14 bit m
  localparam int DIV5_MUL_W = 16;
  localparam logic [DIV5_MUL_W-1:0] DIV5_MUL = 16'd52429;
  localparam int DIV5_SHIFT = 18;

  // operand width of the shared multipliers
  localparam int OP_W = 34;

  // multiplier operand selection
  typedef enum logic [1:0] {
    MUL_DISC_SQ,
    MUL_DISC_Q,
    MUL_ITER
  } mul_sel_t;

  // commands from the controller to the datapath
  typedef struct packed {
    logic     load;
    logic     mul_en;
    mul_sel_t mul_sel;
    logic     q_en;
    logic     z_upd;
    logic     res_load;
    logic     res_disc;
    logic     res_esc;
  } mbe_cmd_t;

  // status from the datapath to the controller
  typedef struct packed {
    logic disc;
    logic mag_esc;
    logic sat_hit;
    logic cnt_zero;
    logic cnt_at_limit;
  } mbe_sts_t;

endpackage

`default_nettype wire

FILE: hdl/mbe_datapath.sv
// datapath: shared multipliers, discard tests, orbit update, result register
`timescale 1ns / 1ps
`default_nettype none

module mbe_datapath import mbe_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic signed [31:0]      in_c_real,
  input  logic signed [31:0]      in_c_imag,
  input  logic                    cfg_we,
  input  logic [CNT_W-1:0]        cfg_max_iterations,
  input  mbe_cmd_t                cmd,
  output mbe_sts_t                sts,
  output logic                    out_discarded,
  output logic                    out_escaped,
  output logic [CNT_W-1:0]        out_orbit_length,
  output logic                    out_accepted
);

  localparam logic signed [OP_W-1:0] QUARTER_G = OP_W'(1) <<< (GUARD_BITS - 2);
  localparam logic signed [OP_W-1:0] ONE_G     = OP_W'(1) <<< GUARD_BITS;
  localparam logic signed [OP_W-1:0] TWO_G     = OP_W'(1) <<< (GUARD_BITS + 1);
  localparam logic signed [OP_W-1:0] NEG_TWO_G = -TWO_G;
  localparam logic signed [63:0]     BULB_THR  = 64'(1) <<< (2 * GUARD_BITS - 4);
  localparam logic [63:0] MAG_THR =
    (2 * FRAC_BITS + 2 < 64) ? (64'(1) << (2 * FRAC_BITS + 2)) : '1;

  // configuration and its fifth
  logic [CNT_W-1:0] max_iter_r, max_iter_nxt;
  logic [CNT_W-1:0] div5_r, div5_nxt;
  logic [CNT_W+DIV5_MUL_W-1:0] div5_prod;

  // point, orbit and products
  logic signed [31:0]     cr_r, ci_r, zr_r, zi_r;
  logic signed [31:0]     zr_nxt, zi_nxt;
  logic signed [63:0]     p0_r, p1_r, p2_r;
  logic signed [OP_W-1:0] q_r, qa_r;
  logic [CNT_W-1:0]       cnt_r;
  logic [CNT_W-1:0]       limit;

  // result register
  logic                   res_disc_r, res_esc_r, res_acc_r;
  logic [CNT_W-1:0]       res_len_r;

  // discard operands
  logic signed [31:0]     x, y;
  logic signed [OP_W-1:0] x_w, y_w, a_w, b_w;
  logic signed [OP_W-1:0] q_w, qa_w;
  logic [63:0]            sq_sum;
  logic [63:0]            q_full;
  logic                   far, card, bulb;
  logic signed [63:0]     bulb_sum;

  // multiplier operands and products
  logic signed [OP_W-1:0]   m0a, m0b, m1a, m1b, m2a, m2b;
  logic signed [2*OP_W-1:0] m0_full, m1_full, m2_full;

  // orbit update
  logic signed [63:0] dr, nr_full, ni_full;
  logic               nr_ovf, ni_ovf;

  // register fifth, worked out when the register is written
  assign div5_prod    = cfg_max_iterations * DIV5_MUL;
  assign max_iter_nxt = cfg_we ? cfg_max_iterations : max_iter_r;
  assign div5_nxt     = cfg_we ? CNT_W'(div5_prod >> DIV5_SHIFT) : div5_r;

  // effective step limit
  assign limit = (32'(max_iter_r) > ITER_LIMIT) ? CNT_W'(ITER_LIMIT) : max_iter_r;

  // discard operands at guard precision
  assign x   = cr_r >>> DISC_SHIFT;
  assign y   = ci_r >>> DISC_SHIFT;
  assign x_w = {{(OP_W-32){x[31]}}, x};
  assign y_w = {{(OP_W-32){y[31]}}, y};
  assign a_w = x_w - QUARTER_G;
  assign b_w = x_w + ONE_G;

  // shared sum of squares: q for the cardioid, |z|^2 for escape
  assign sq_sum = p0_r + p1_r;
  assign q_full = sq_sum >> GUARD_BITS;
  assign q_w    = q_full[OP_W-1:0];
  assign qa_w   = q_w + a_w;

  // operand selection
  always_comb begin
    case (cmd.mul_sel)
      MUL_DISC_SQ: begin
        m0a = a_w; m0b = a_w;
        m1a = y_w; m1b = y_w;
        m2a = b_w; m2b = b_w;
      end
      MUL_DISC_Q: begin
        m0a = q_r; m0b = qa_r;
        m1a = y_w; m1b = y_w;
        m2a = b_w; m2b = b_w;
      end
      default: begin
        m0a = {{(OP_W-32){zr_r[31]}}, zr_r};
        m0b = {{(OP_W-32){zr_r[31]}}, zr_r};
        m1a = {{(OP_W-32){zi_r[31]}}, zi_r};
        m1b = {{(OP_W-32){zi_r[31]}}, zi_r};
        m2a = {{(OP_W-32){zr_r[31]}}, zr_r};
        m2b = {{(OP_W-32){zi_r[31]}}, zi_r};
      end
    endcase
  end

  assign m0_full = m0a * m0b;
  assign m1_full = m1a * m1b;
  assign m2_full = m2a * m2b;

  // cardioid and bulb tests, skipped for far points
  assign far = (x_w >= TWO_G) || (x_w <= NEG_TWO_G) ||
               (y_w >= TWO_G) || (y_w <= NEG_TWO_G);
  assign card     = p0_r < (p1_r >>> 2);
  assign bulb_sum = p2_r + p1_r;
  assign bulb     = bulb_sum < BULB_THR;

  // next z with floor scaling and saturation
  assign dr      = p0_r - p1_r;
  assign nr_full = (dr >>> FRAC_BITS) + $signed({{32{cr_r[31]}}, cr_r});
  assign ni_full = (p2_r >>> (FRAC_BITS - 1)) + $signed({{32{ci_r[31]}}, ci_r});
  assign nr_ovf  = (nr_full[63:31] != '0) && (nr_full[63:31] != '1);
  assign ni_ovf  = (ni_full[63:31] != '0) && (ni_full[63:31] != '1);

  always_comb begin
    if (nr_ovf) begin
      zr_nxt = nr_full[63] ? 32'sh8000_0000 : 32'sh7fff_ffff;
    end else begin
      zr_nxt = nr_full[31:0];
    end
    if (ni_ovf) begin
      zi_nxt = ni_full[63] ? 32'sh8000_0000 : 32'sh7fff_ffff;
    end else begin
      zi_nxt = ni_full[31:0];
    end
  end

  // status to the controller
  assign sts.disc         = !far && (card || bulb);
  assign sts.mag_esc      = sq_sum > MAG_THR;
  assign sts.sat_hit      = nr_ovf || ni_ovf;
  assign sts.cnt_zero     = cnt_r == '0;
  assign sts.cnt_at_limit = cnt_r == limit;

  // configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_iter_r <= MAX_ITER_RESET;
      div5_r     <= DIV5_RESET;
    end else begin
      max_iter_r <= max_iter_nxt;
      div5_r     <= div5_nxt;
    end
  end

  // point, orbit, products and count
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cr_r  <= in_c_real;
      ci_r  <= in_c_imag;
      zr_r  <= in_c_real;
      zi_r  <= in_c_imag;
      cnt_r <= '0;
    end else if (cmd.z_upd) begin
      zr_r  <= zr_nxt;
      zi_r  <= zi_nxt;
      cnt_r <= cnt_r + 1'b1;
    end
    if (cmd.mul_en) begin
      p0_r <= m0_full[63:0];
      if (cmd.mul_sel != MUL_DISC_Q) begin
        p1_r <= m1_full[63:0];
        p2_r <= m2_full[63:0];
      end
    end
    if (cmd.q_en) begin
      q_r  <= q_w;
      qa_r <= qa_w;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      res_disc_r <= cmd.res_disc;
      res_esc_r  <= cmd.res_esc;
      res_len_r  <= cnt_r;
      res_acc_r  <= cmd.res_esc && (cnt_r > div5_r);
    end
  end

  assign out_discarded    = res_disc_r;
  assign out_escaped      = res_esc_r;
  assign out_orbit_length = res_len_r;
  assign out_accepted     = res_acc_r;

endmodule

`default_nettype wire

FILE: hdl/mbe_ctrl.sv
// controller: sequences the discard tests and the escape iteration
`timescale 1ns / 1ps
`default_nettype none

module mbe_ctrl import mbe_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  output logic     out_valid,
  input  logic     out_stall,
  output mbe_cmd_t cmd,
  input  mbe_sts_t sts
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DSQ,
    S_DQ,
    S_DPROD,
    S_DDEC,
    S_MUL,
    S_UPD,
    S_FIN
  } state_t;

  state_t state_r, state_nxt;
  logic   disc_r, disc_nxt;
  logic   esc_r, esc_nxt;
  logic   out_valid_r, out_valid_nxt;

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    disc_nxt  = disc_r;
    esc_nxt   = esc_r;
    cmd          = '0;
    cmd.mul_sel  = MUL_ITER;
    cmd.res_disc = disc_r;
    cmd.res_esc  = esc_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_DSQ;
        end
      end
      S_DSQ: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_DISC_SQ;
        state_nxt   = S_DQ;
      end
      S_DQ: begin
        cmd.q_en  = 1'b1;
        state_nxt = S_DPROD;
      end
      S_DPROD: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_DISC_Q;
        state_nxt   = S_DDEC;
      end
      S_DDEC: begin
        disc_nxt = sts.disc;
        esc_nxt  = 1'b0;
        if (sts.disc) begin
          state_nxt = S_FIN;
        end else begin
          state_nxt = S_MUL;
        end
      end
      S_MUL: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_ITER;
        state_nxt   = S_UPD;
      end
      S_UPD: begin
        if (!sts.cnt_zero && sts.mag_esc) begin
          esc_nxt   = 1'b1;
          state_nxt = S_FIN;
        end else if (sts.cnt_at_limit) begin
          esc_nxt   = 1'b0;
          state_nxt = S_FIN;
        end else begin
          cmd.z_upd = 1'b1;
          if (sts.sat_hit) begin
            esc_nxt   = 1'b1;
            state_nxt = S_FIN;
          end else begin
            state_nxt = S_MUL;
          end
        end
      end
      S_FIN: begin
        if (!out_valid_r || !out_stall) begin
          cmd.res_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // result valid: set on load, cleared when taken
  assign out_valid_nxt = cmd.res_load ? 1'b1 : (out_valid_r && out_stall);

  // state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      disc_r      <= 1'b0;
      esc_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      disc_r      <= disc_nxt;
      esc_r       <= esc_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = state_r != S_IDLE;
  assign out_valid = out_valid_r;

endmodule

`default_nettype wire

FILE: hdl/mandelbrot_escape_test.sv
// top level of the mandelbrot escape-time test with cardioid and bulb rejection
`timescale 1ns / 1ps
`default_nettype none

// Takes one point c (signed Q4.28) per request and returns one result per
// request. A request is taken in S_IDLE, then the states S_DSQ, S_DQ, S_DPROD
// and S_DDEC run the cardioid and period-2 bulb tests through the three shared
// multipliers; a discarded point finishes there. Otherwise each orbit step
// uses the same multipliers in S_MUL and S_UPD (products, then escape check
// and z update), and the number of steps run is at most max_iterations. One
// point is in flight at a time; a finished result waits in the output
// register while the next request is taken. max_iterations is written through
// the cfg_ port, which is always ready, and must only be written while the
// block is idle.
module mandelbrot_escape_test import mbe_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [31:0] in_c_real,
  input  logic signed [31:0] in_c_imag,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               out_discarded,
  output logic               out_escaped,
  output logic [CNT_W-1:0]   out_orbit_length,
  output logic               out_accepted,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [CNT_W-1:0]   cfg_max_iterations
);

  mbe_cmd_t cmd;
  mbe_sts_t sts;

  // register port never holds off a write
  assign cfg_ready = 1'b1;

  // controller
  mbe_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .sts       (sts)
  );

  // datapath
  mbe_datapath u_datapath (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_c_real          (in_c_real),
    .in_c_imag          (in_c_imag),
    .cfg_we             (cfg_valid && cfg_ready),
    .cfg_max_iterations (cfg_max_iterations),
    .cmd                (cmd),
    .sts                (sts),
    .out_discarded      (out_discarded),
    .out_escaped        (out_escaped),
    .out_orbit_length   (out_orbit_length),
    .out_accepted       (out_accepted)
  );

endmodule

`default_nettype wire
